// ----- design/sfe_pkg.sv -----
// Shared types, constants and byte functions of the scrambled frame encoder.
// Used by the front, queue and back modules; depends on nothing.
package sfe_pkg;

    localparam int unsigned ADDR_BYTES = 5;
    localparam int unsigned ADDR_W     = 8 * ADDR_BYTES;
    localparam int unsigned SCR_LEN    = 39;
    localparam int unsigned XO_LEN     = 35;
    localparam int unsigned TAB_IW     = 6;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_AW       = 2;

    localparam logic [15:0] CRC_INIT = 16'hB5D2;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef enum logic [7:0] {
        STEP_ADDR0  = 8'b0000_0001,
        STEP_ADDR1  = 8'b0000_0010,
        STEP_ADDR2  = 8'b0000_0100,
        STEP_ADDR3  = 8'b0000_1000,
        STEP_ADDR4  = 8'b0001_0000,
        STEP_DATA   = 8'b0010_0000,
        STEP_CRC_HI = 8'b0100_0000,
        STEP_CRC_LO = 8'b1000_0000
    } t_step;

    localparam logic [7:0] SCR_TAB [SCR_LEN] = '{
        8'hE3, 8'hB1, 8'h4B, 8'hEA, 8'h85, 8'hBC, 8'hE5, 8'h66, 8'h0D, 8'hAE,
        8'h8C, 8'h88, 8'h12, 8'h69, 8'hEE, 8'h1F, 8'hC7, 8'h62, 8'h97, 8'hD5,
        8'h0B, 8'h79, 8'hCA, 8'hCC, 8'h1B, 8'h5D, 8'h19, 8'h10, 8'h24, 8'hD3,
        8'hDC, 8'h3F, 8'h8E, 8'hC5, 8'h2F, 8'hAA, 8'h16, 8'hF3, 8'h95
    };

    localparam logic [15:0] XO_TAB [XO_LEN] = '{
        16'h0000, 16'h3448, 16'h9BA7, 16'h8BBB, 16'h85E1, 16'h3E8C, 16'h451E,
        16'h18E6, 16'h6B24, 16'hE7AB, 16'h3828, 16'h814B, 16'hD461, 16'hF494,
        16'h2503, 16'h691D, 16'hFE8B, 16'h9BA7, 16'h8B17, 16'h2920, 16'h8B5F,
        16'h61B1, 16'hD391, 16'h7401, 16'h2138, 16'h129F, 16'hB3A0, 16'h2988,
        16'h23CA, 16'hC0CB, 16'h0C6C, 16'hB329, 16'hA0A1, 16'h0A16, 16'hA9D0
    };

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        ovf;
        logic        last;
        logic [15:0] xorout;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
        logic [15:0] c;
        logic [7:0]  d;
        logic        top;
        c = crc;
        d = v;
        for (int k = 0; k < 8; k++) begin
            top = c[15] ^ d[7];
            c = {c[14:0], 1'b0} ^ (top ? CRC_POLY : 16'h0000);
            d = {d[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- design/sfe_front.sv -----
// Front part: accepts payload bytes, tracks frame position and classifies each beat.
// Scrambles the payload byte and picks the CRC xorout word; uses sfe_pkg.
module sfe_front #(
    parameter int unsigned MAX_PAYLOAD = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_payload_byte,
    input  logic          i_end_of_payload,
    output sfe_pkg::t_push o_push
);
    import sfe_pkg::*;

    localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);

    logic [CW-1:0] r_count, n_count;
    logic          r_in_frame, n_in_frame;

    logic [CW-1:0]     cnt;
    logic              ovf;
    logic [CW-1:0]     new_cnt;
    logic [TAB_IW-1:0] scr_idx;
    logic [TAB_IW-1:0] xo_idx;

    always_comb begin
        cnt     = r_in_frame ? r_count : '0;
        ovf     = (cnt >= MAX_CNT);
        new_cnt = ovf ? cnt : cnt + CW'(1);
        scr_idx = TAB_IW'(cnt) + TAB_IW'(ADDR_BYTES);
        xo_idx  = TAB_IW'(new_cnt) + TAB_IW'(2);

        o_push.valid        = i_accept;
        o_push.entry.data   = rev8(i_payload_byte) ^ SCR_TAB[scr_idx];
        o_push.entry.first  = !r_in_frame;
        o_push.entry.ovf    = ovf;
        o_push.entry.last   = i_end_of_payload;
        o_push.entry.xorout = XO_TAB[xo_idx];

        n_count    = r_count;
        n_in_frame = r_in_frame;
        if (i_accept) begin
            n_count    = i_end_of_payload ? '0 : new_cnt;
            n_in_frame = !i_end_of_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_in_frame <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_in_frame <= n_in_frame;
        end
    end

endmodule

// ----- design/sfe_queue.sv -----
// Short queue of classified beats between the front and back parts.
// Register-based ring with full/empty flags; uses sfe_pkg.
module sfe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfe_pkg::t_push i_push,
    input  logic           i_pop,
    output sfe_pkg::t_head o_head,
    output logic           o_full
);
    import sfe_pkg::*;

    t_entry r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]   r_fill, n_fill;

    logic do_push;
    logic do_pop;

    always_comb begin
        do_push  = i_push.valid;
        do_pop   = i_pop && (r_fill != '0);
        n_wr_ptr = do_push ? r_wr_ptr + Q_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + Q_AW'(1) : r_rd_ptr;
        n_fill   = r_fill + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);

        o_head.valid = (r_fill != '0);
        o_head.entry = r_mem[r_rd_ptr];
        o_full       = (r_fill == (Q_AW+1)'(Q_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

endmodule

// ----- design/sfe_back.sv -----
// Back part: walks each queued beat through its address, payload and CRC bytes.
// Holds the address register, the running CRC and the output register; uses sfe_pkg.
module sfe_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [sfe_pkg::ADDR_W-1:0] i_cfg_data,
    input  sfe_pkg::t_head           i_head,
    output logic                     o_pop,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [7:0]               o_frame_byte,
    output logic                     o_run_last,
    output logic                     o_frame_last,
    output logic                     o_overflow_error
);
    import sfe_pkg::*;

    logic [ADDR_W-1:0] r_tx_address;
    logic [15:0]       r_crc, n_crc;
    logic              r_mid, n_mid;
    t_step             r_step, n_step;
    logic              r_valid, n_valid;
    logic [7:0]        r_byte, n_byte;
    logic              r_run_last, n_run_last;
    logic              r_frame_last, n_frame_last;
    logic              r_ovf, n_ovf;

    logic              load;
    logic              emit;
    t_step             step;
    t_step             step_next;
    logic [7:0]        b;
    logic              upd_crc;
    logic [15:0]       crc_out;
    logic              fin;

    always_comb begin
        load    = !r_valid || !i_stall;
        emit    = load && i_head.valid;
        if (r_mid) begin
            step = r_step;
        end else if (i_head.entry.first) begin
            step = STEP_ADDR0;
        end else begin
            step = STEP_DATA;
        end
        crc_out   = r_crc ^ i_head.entry.xorout;
        upd_crc   = 1'b1;
        b         = '0;
        step_next = STEP_ADDR0;
        case (step)
            STEP_ADDR0: begin
                b         = r_tx_address[39:32] ^ SCR_TAB[0];
                step_next = STEP_ADDR1;
            end
            STEP_ADDR1: begin
                b         = r_tx_address[31:24] ^ SCR_TAB[1];
                step_next = STEP_ADDR2;
            end
            STEP_ADDR2: begin
                b         = r_tx_address[23:16] ^ SCR_TAB[2];
                step_next = STEP_ADDR3;
            end
            STEP_ADDR3: begin
                b         = r_tx_address[15:8]  ^ SCR_TAB[3];
                step_next = STEP_ADDR4;
            end
            STEP_ADDR4: begin
                b         = r_tx_address[7:0]   ^ SCR_TAB[4];
                step_next = STEP_DATA;
            end
            STEP_DATA: begin
                b         = i_head.entry.ovf ? 8'h00 : i_head.entry.data;
                upd_crc   = !i_head.entry.ovf;
                step_next = STEP_CRC_HI;
            end
            STEP_CRC_HI: begin
                b         = crc_out[15:8];
                upd_crc   = 1'b0;
                step_next = STEP_CRC_LO;
            end
            STEP_CRC_LO: begin
                b         = crc_out[7:0];
                upd_crc   = 1'b0;
                step_next = STEP_ADDR0;
            end
            default: begin
                b         = '0;
                upd_crc   = 1'b0;
                step_next = STEP_ADDR0;
            end
        endcase

        fin = (step == STEP_CRC_LO) || ((step == STEP_DATA) && !i_head.entry.last);

        n_valid      = r_valid;
        n_byte       = r_byte;
        n_run_last   = r_run_last;
        n_frame_last = r_frame_last;
        n_ovf        = r_ovf;
        n_crc        = r_crc;
        n_mid        = r_mid;
        n_step       = r_step;
        if (load) begin
            n_valid = i_head.valid;
        end
        if (emit) begin
            n_byte       = b;
            n_run_last   = fin;
            n_frame_last = (step == STEP_CRC_LO);
            n_ovf        = (step == STEP_DATA) && i_head.entry.ovf;
            if (step == STEP_CRC_LO) begin
                n_crc = CRC_INIT;
            end else if (upd_crc) begin
                n_crc = crc_byte(r_crc, b);
            end
            n_mid  = !fin;
            n_step = step_next;
        end

        o_pop            = emit && fin;
        o_valid          = r_valid;
        o_frame_byte     = r_byte;
        o_run_last       = r_run_last;
        o_frame_last     = r_frame_last;
        o_overflow_error = r_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_address <= '0;
            r_crc        <= CRC_INIT;
            r_mid        <= 1'b0;
            r_step       <= STEP_ADDR0;
            r_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tx_address <= i_cfg_data;
            end
            r_crc   <= n_crc;
            r_mid   <= n_mid;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte       <= n_byte;
        r_run_last   <= n_run_last;
        r_frame_last <= n_frame_last;
        r_ovf        <= n_ovf;
    end

endmodule

// ----- design/scrambled_frame_encoder_crc16_unit.sv -----
// Top level of the scrambled CRC-16 frame encoder.
// Instantiates sfe_front, sfe_queue and sfe_back; uses sfe_pkg.
//
// Each accepted payload beat yields one to eight frame bytes: the first beat of a frame
// adds the five scrambled address bytes, the beat marked end_of_payload adds the two
// CRC bytes, and a beat past MAX_PAYLOAD yields one zero byte flagged overflow_error.
// The input takes one beat per cycle while the four-entry queue has room; the back part
// emits one frame byte per cycle unless i_stall holds its output register. A middle beat
// has one byte, a first beat six, a last beat three and a one-byte frame eight, and that
// byte count sets the sustained rate. A byte is loaded into the output register from the
// beat at the queue head while that register is empty or not stalled.
// The address register is read while the first beat of a frame sits at the queue head.
module scrambled_frame_encoder_crc16_unit #(
    parameter int unsigned MAX_PAYLOAD = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sfe_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_payload_byte,
    input  logic                       i_end_of_payload,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [7:0]                 o_frame_byte,
    output logic                       o_run_last,
    output logic                       o_frame_last,
    output logic                       o_overflow_error
);
    import sfe_pkg::*;

    t_push push;
    t_head head;
    logic  full;
    logic  pop;
    logic  accept;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    sfe_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_payload_byte   (i_payload_byte),
        .i_end_of_payload (i_end_of_payload),
        .o_push           (push)
    );

    sfe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    sfe_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_head           (head),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_frame_byte     (o_frame_byte),
        .o_run_last       (o_run_last),
        .o_frame_last     (o_frame_last),
        .o_overflow_error (o_overflow_error)
    );

endmodule

// ----- design/sfe_checker.sv -----
// Port-level checks for the scrambled frame encoder, bound to the top level.
// Sees the top-level handshake and field ports only; depends on nothing else.
module sfe_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic [7:0]                 i_payload_byte,
    input logic                       i_end_of_payload,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [7:0]                 o_frame_byte,
    input logic                       o_run_last,
    input logic                       o_frame_last,
    input logic                       o_overflow_error
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output beat valid right after reset");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_payload_byte)
        && $stable(i_end_of_payload)))
        else $error("stalled input beat changed");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_frame_byte) && $stable(o_run_last)
        && $stable(o_frame_last) && $stable(o_overflow_error)))
        else $error("stalled output beat changed");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_last) |-> o_run_last)
        else $error("frame end not marked as last of its input beat");

    a_ovf_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow_error) |-> (o_frame_byte == 8'h00 && !o_frame_last))
        else $error("overflow beat carries data or closes the frame");

endmodule

bind scrambled_frame_encoder_crc16_unit sfe_checker u_sfe_checker (.*);
